// ===== hw/rtl/double_ended_queue_defines.svh =====
// Assertion macros for the double-ended queue checker.
// No dependencies; expects aclk and aresetn in the including scope.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// check while out of reset
`define DEQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check at every edge, reset included
`define DEQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hw/rtl/deq_pkg.sv =====
// Shared constants, codes and ring index helper for the double-ended queue.
// No dependencies.
`default_nettype none

package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int ITEM_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int COUNT_W    = $clog2(DEPTH + 1);
    localparam int FUNC_W     = 3;
    localparam int STATUS_W   = 2;

    localparam int S_BITS     = FUNC_W + ITEM_WIDTH;
    localparam int S_TDATA_W  = ((S_BITS + 7) / 8) * 8;

    localparam int VALUE_LSB  = 0;
    localparam int STATUS_LSB = VALUE_LSB + ITEM_WIDTH;
    localparam int COUNT_LSB  = STATUS_LSB + STATUS_W;
    localparam int EMPTY_LSB  = COUNT_LSB + COUNT_W;
    localparam int M_BITS     = EMPTY_LSB + 1;
    localparam int M_TDATA_W  = ((M_BITS + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH_R = 3'd0,
        OP_POP_L  = 3'd1,
        OP_POP_R  = 3'd2,
        OP_PEEK_L = 3'd3,
        OP_PEEK_R = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // base + offset modulo DEPTH, offset below DEPTH
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                   input logic [COUNT_W-1:0] offset);
        logic [COUNT_W:0] sum;
        sum = (COUNT_W + 1)'(base) + (COUNT_W + 1)'(offset);
        if (sum >= (COUNT_W + 1)'(DEPTH)) begin
            sum = sum - (COUNT_W + 1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/deq_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/double_ended_queue.sv =====
// Double-ended queue over a ring store in one RAM, with a registered result word.
// Depends on deq_pkg and deq_ram.
//
//  channel  | dir | tdata fields (lsb first)                          | tuser | tlast
//  s_axis   | in  | func[2:0], push_value[31:0], pad                  | -     | -
//  m_axis   | out | item_value[31:0], status[1:0], entry_count[4:0], empty_flag | - | -
//
// Push, underflow and unknown ops: result word valid in the cycle after accept.
// Pop and peek: the item passes through the registered RAM read, then the result register.
// One word in flight; a new word is taken once the result register is free or draining.
// Reset clears state, pointer, count and valid; RAM contents need no clearing.
// A stalled result word holds and blocks new input words.
`default_nettype none

module double_ended_queue (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // func, push_value, zero pad
    input  wire logic [deq_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // item_value, status, entry_count, empty_flag
    output logic      [deq_pkg::M_TDATA_W-1:0]  m_tdata
);

    import deq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t                state_reg, state_next;
    logic [ADDR_W-1:0]     left_reg, left_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic                  out_valid_reg, out_valid_next;
    logic [ITEM_WIDTH-1:0] out_value_reg, out_value_next;
    status_t               out_status_reg, out_status_next;
    logic [COUNT_W-1:0]    out_count_reg, out_count_next;
    logic                  out_empty_reg, out_empty_next;

    logic                  accept;
    logic                  out_free;
    logic [FUNC_W-1:0]     func;
    logic [ITEM_WIDTH-1:0] push_value;
    logic                  wr_en;
    logic                  rd_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ITEM_WIDTH-1:0] rd_data;

    assign func       = s_tdata[FUNC_W-1:0];
    assign push_value = s_tdata[FUNC_W +: ITEM_WIDTH];
    assign out_free   = !out_valid_reg || m_tready;
    assign s_tready   = (state_reg == S_IDLE) && out_free;
    assign accept     = s_tvalid && s_tready;
    assign wr_addr    = ring_add(left_reg, count_reg);

    deq_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (push_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next      = state_reg;
        left_next       = left_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_empty_next  = out_empty_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = left_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    out_value_next  = '0;
                    out_status_next = ST_OK;
                    out_count_next  = count_reg;
                    out_empty_next  = (count_reg == '0);
                    out_valid_next  = 1'b1;
                    case (func)
                        OP_PUSH_R: begin
                            if (count_reg == COUNT_W'(DEPTH)) begin
                                out_status_next = ST_FULL;
                            end else begin
                                wr_en          = 1'b1;
                                count_next     = count_reg + 1'b1;
                                out_count_next = count_reg + 1'b1;
                                out_empty_next = 1'b0;
                            end
                        end
                        OP_POP_L, OP_POP_R, OP_PEEK_L, OP_PEEK_R: begin
                            if (count_reg == '0) begin
                                out_status_next = ST_UNDER;
                            end else begin
                                rd_en          = 1'b1;
                                out_valid_next = 1'b0;
                                state_next     = S_READ;
                                if (func == OP_POP_R || func == OP_PEEK_R) begin
                                    rd_addr = ring_add(left_reg, count_reg - 1'b1);
                                end
                                if (func == OP_POP_L) begin
                                    left_next  = ring_add(left_reg, COUNT_W'(1));
                                    count_next = count_reg - 1'b1;
                                end
                                if (func == OP_POP_R) begin
                                    count_next = count_reg - 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_value_next  = rd_data;
                    out_status_next = ST_OK;
                    out_count_next  = count_reg;
                    out_empty_next  = (count_reg == '0);
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            left_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            left_reg      <= left_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_empty_reg  <= out_empty_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_empty_reg, out_count_reg, out_status_reg, out_value_reg});

endmodule

`default_nettype wire

// ===== hw/rtl/deq_checker.sv =====
// Port-level checks for the double-ended queue, bound to the top level.
// Depends on deq_pkg and double_ended_queue_defines.svh.
`default_nettype none

`include "double_ended_queue_defines.svh"

module deq_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [deq_pkg::M_TDATA_W-1:0] m_tdata
);

    import deq_pkg::*;

    logic [ITEM_WIDTH-1:0] item_value;
    logic [STATUS_W-1:0]   status;
    logic [COUNT_W-1:0]    entry_count;
    logic                  empty_flag;

    assign item_value  = m_tdata[VALUE_LSB +: ITEM_WIDTH];
    assign status      = m_tdata[STATUS_LSB +: STATUS_W];
    assign entry_count = m_tdata[COUNT_LSB +: COUNT_W];
    assign empty_flag  = m_tdata[EMPTY_LSB];

    `DEQ_ASSERT_ALWAYS(a_no_word_after_reset, !aresetn |=> !m_tvalid, "result word right after reset")
    `DEQ_ASSERT(a_hold_stalled, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result word changed")
    `DEQ_ASSERT(a_count_flags, m_tvalid |-> entry_count <= COUNT_W'(DEPTH) && empty_flag == (entry_count == '0), "count and empty flag disagree")
    `DEQ_ASSERT(a_underflow_word, m_tvalid && status == ST_UNDER |-> item_value == '0 && empty_flag, "underflow with data or items held")
    `DEQ_ASSERT(a_full_word, m_tvalid && status == ST_FULL |-> item_value == '0 && entry_count == COUNT_W'(DEPTH), "dropped push while not full")

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

`default_nettype wire
